FILE: src/clwc_pkg.sv
package clwc_pkg;

  // Defaults for the top-level parameters.
  localparam int ColumnsDefault    = 16;
  localparam int ValueWidthDefault = 32;

  // Fixed byte constants.
  localparam logic [7:0] ClearCmd  = 8'h01;
  localparam logic [7:0] ColMask   = 8'h0F;
  localparam logic [7:0] AsciiZero = 8'h30;

  // Configuration register indexes and reset values.
  localparam int CfgIdxW = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FUNCTION_SET  = 3'd0,
    REG_DISPLAY_CTRL  = 3'd1,
    REG_INIT_CLEAR    = 3'd2,
    REG_ENTRY_MODE    = 3'd3,
    REG_ROW0_BASE     = 3'd4,
    REG_ROW1_BASE     = 3'd5
  } cfg_idx_e;

  localparam logic [7:0] FunctionSetRst = 8'd56;
  localparam logic [7:0] DisplayCtrlRst = 8'd12;
  localparam logic [7:0] InitClearRst   = 8'd1;
  localparam logic [7:0] EntryModeRst   = 8'd6;
  localparam logic [7:0] Row0BaseRst    = 8'd128;
  localparam logic [7:0] Row1BaseRst    = 8'd192;

  typedef struct packed {
    logic [7:0] function_set_cmd;
    logic [7:0] display_control_cmd;
    logic [7:0] init_clear_cmd;
    logic [7:0] entry_mode_cmd;
    logic [7:0] row0_base;
    logic [7:0] row1_base;
  } cfg_t;

  // Request opcodes.
  typedef enum logic [2:0] {
    OP_INIT   = 3'd0,
    OP_CMD    = 3'd1,
    OP_CHAR   = 3'd2,
    OP_GOTO   = 3'd3,
    OP_CLEAR  = 3'd4,
    OP_NUMBER = 3'd5
  } opcode_e;

  // Microcode fields.
  typedef logic [3:0] upc_t;

  typedef enum logic [2:0] {
    SRC_FUNC,
    SRC_DISP,
    SRC_ICLR,
    SRC_ENTRY,
    SRC_DATA,
    SRC_GOTO,
    SRC_CLEAR,
    SRC_DIGIT
  } src_e;

  typedef enum logic [1:0] {
    LAST_NO,
    LAST_YES,
    LAST_FINAL
  } last_e;

  typedef enum logic [1:0] {
    DP_NONE,
    DP_CONV,
    DP_SKIP,
    DP_DIGIT
  } dp_op_e;

  typedef enum logic [2:0] {
    CD_ALWAYS,
    CD_GOTO_OK,
    CD_CONV_BUSY,
    CD_LEAD_ZERO,
    CD_MORE_DIGITS
  } cond_e;

  typedef struct packed {
    logic   emit;
    src_e   src;
    logic   is_data;
    last_e  last;
    dp_op_e op;
    cond_e  cond;
    logic   dispatch;
    upc_t   addr_t;
    upc_t   addr_f;
  } ctrl_t;

  // Datapath flags seen by the sequencer.
  typedef struct packed {
    logic goto_ok;
    logic conv_busy;
    logic lead_zero;
    logic more_digits;
    logic out_busy;
  } stat_t;

  // Microprogram entry points.
  localparam upc_t A_IDLE    = 4'd0;
  localparam upc_t A_INIT    = 4'd1;
  localparam upc_t A_INIT1   = 4'd2;
  localparam upc_t A_INIT2   = 4'd3;
  localparam upc_t A_INIT3   = 4'd4;
  localparam upc_t A_CMD     = 4'd5;
  localparam upc_t A_CHAR    = 4'd6;
  localparam upc_t A_GOTO    = 4'd7;
  localparam upc_t A_GOTO_WR = 4'd8;
  localparam upc_t A_CLEAR   = 4'd9;
  localparam upc_t A_CONV    = 4'd10;
  localparam upc_t A_SKIP    = 4'd11;
  localparam upc_t A_DIGIT   = 4'd12;

  function automatic ctrl_t cw(logic emit, src_e src, logic is_data, last_e last,
                               dp_op_e op, cond_e cond, logic dispatch,
                               upc_t addr_t, upc_t addr_f);
    ctrl_t c;
    c.emit     = emit;
    c.src      = src;
    c.is_data  = is_data;
    c.last     = last;
    c.op       = op;
    c.cond     = cond;
    c.dispatch = dispatch;
    c.addr_t   = addr_t;
    c.addr_f   = addr_f;
    return c;
  endfunction

  // Control store: one word per step.
  function automatic ctrl_t ucode(upc_t addr);
    ctrl_t c;
    unique case (addr)
      A_IDLE:    c = cw(1'b0, SRC_DATA,  1'b0, LAST_NO,    DP_NONE,  CD_ALWAYS,
                        1'b1, A_IDLE, A_IDLE);
      A_INIT:    c = cw(1'b1, SRC_FUNC,  1'b0, LAST_NO,    DP_NONE,  CD_ALWAYS,
                        1'b0, A_INIT1, A_INIT1);
      A_INIT1:   c = cw(1'b1, SRC_DISP,  1'b0, LAST_NO,    DP_NONE,  CD_ALWAYS,
                        1'b0, A_INIT2, A_INIT2);
      A_INIT2:   c = cw(1'b1, SRC_ICLR,  1'b0, LAST_NO,    DP_NONE,  CD_ALWAYS,
                        1'b0, A_INIT3, A_INIT3);
      A_INIT3:   c = cw(1'b1, SRC_ENTRY, 1'b0, LAST_YES,   DP_NONE,  CD_ALWAYS,
                        1'b0, A_IDLE, A_IDLE);
      A_CMD:     c = cw(1'b1, SRC_DATA,  1'b0, LAST_YES,   DP_NONE,  CD_ALWAYS,
                        1'b0, A_IDLE, A_IDLE);
      A_CHAR:    c = cw(1'b1, SRC_DATA,  1'b1, LAST_YES,   DP_NONE,  CD_ALWAYS,
                        1'b0, A_IDLE, A_IDLE);
      A_GOTO:    c = cw(1'b0, SRC_GOTO,  1'b0, LAST_NO,    DP_NONE,  CD_GOTO_OK,
                        1'b0, A_GOTO_WR, A_IDLE);
      A_GOTO_WR: c = cw(1'b1, SRC_GOTO,  1'b0, LAST_YES,   DP_NONE,  CD_ALWAYS,
                        1'b0, A_IDLE, A_IDLE);
      A_CLEAR:   c = cw(1'b1, SRC_CLEAR, 1'b0, LAST_YES,   DP_NONE,  CD_ALWAYS,
                        1'b0, A_IDLE, A_IDLE);
      A_CONV:    c = cw(1'b0, SRC_DIGIT, 1'b1, LAST_NO,    DP_CONV,  CD_CONV_BUSY,
                        1'b0, A_CONV, A_SKIP);
      A_SKIP:    c = cw(1'b0, SRC_DIGIT, 1'b1, LAST_NO,    DP_SKIP,  CD_LEAD_ZERO,
                        1'b0, A_SKIP, A_DIGIT);
      A_DIGIT:   c = cw(1'b1, SRC_DIGIT, 1'b1, LAST_FINAL, DP_DIGIT, CD_MORE_DIGITS,
                        1'b0, A_DIGIT, A_IDLE);
      default:   c = cw(1'b0, SRC_DATA,  1'b0, LAST_NO,    DP_NONE,  CD_ALWAYS,
                        1'b0, A_IDLE, A_IDLE);
    endcase
    return c;
  endfunction

  // Entry point for each request opcode.
  function automatic upc_t dispatch(logic [2:0] op);
    upc_t a;
    unique case (opcode_e'(op))
      OP_INIT:   a = A_INIT;
      OP_CMD:    a = A_CMD;
      OP_CHAR:   a = A_CHAR;
      OP_GOTO:   a = A_GOTO;
      OP_CLEAR:  a = A_CLEAR;
      OP_NUMBER: a = A_CONV;
      default:   a = A_IDLE;
    endcase
    return a;
  endfunction

endpackage

FILE: src/clwc_cfg_regs.sv
module clwc_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [clwc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  output clwc_pkg::cfg_t              cfg_o
);

  clwc_pkg::cfg_t cfg_q;

  // Writes are always taken; ready is tied high.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Register file; unknown indexes are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.function_set_cmd    <= clwc_pkg::FunctionSetRst;
      cfg_q.display_control_cmd <= clwc_pkg::DisplayCtrlRst;
      cfg_q.init_clear_cmd      <= clwc_pkg::InitClearRst;
      cfg_q.entry_mode_cmd      <= clwc_pkg::EntryModeRst;
      cfg_q.row0_base           <= clwc_pkg::Row0BaseRst;
      cfg_q.row1_base           <= clwc_pkg::Row1BaseRst;
    end else if (cfg_valid_i) begin
      case (clwc_pkg::cfg_idx_e'(cfg_index_i))
        clwc_pkg::REG_FUNCTION_SET: cfg_q.function_set_cmd    <= cfg_data_i;
        clwc_pkg::REG_DISPLAY_CTRL: cfg_q.display_control_cmd <= cfg_data_i;
        clwc_pkg::REG_INIT_CLEAR:   cfg_q.init_clear_cmd      <= cfg_data_i;
        clwc_pkg::REG_ENTRY_MODE:   cfg_q.entry_mode_cmd      <= cfg_data_i;
        clwc_pkg::REG_ROW0_BASE:    cfg_q.row0_base           <= cfg_data_i;
        clwc_pkg::REG_ROW1_BASE:    cfg_q.row1_base           <= cfg_data_i;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/clwc_sequencer.sv
module clwc_sequencer (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [2:0]            opcode_i,
  output logic                  in_stall_o,
  output logic                  in_fire_o,
  input  clwc_pkg::stat_t       stat_i,
  output clwc_pkg::ctrl_t       ctrl_o,
  output logic                  adv_o
);

  clwc_pkg::upc_t upc_q, upc_d;
  logic           cond_true;

  // Control word of the current step.
  assign ctrl_o = clwc_pkg::ucode(upc_q);

  // A write step waits while the output register is full and stalled.
  assign adv_o = !(ctrl_o.emit && stat_i.out_busy);

  // Requests are taken only at the idle step.
  assign in_stall_o = (upc_q != clwc_pkg::A_IDLE);
  assign in_fire_o  = in_valid_i && !in_stall_o;

  // Jump condition select.
  always_comb begin
    unique case (ctrl_o.cond)
      clwc_pkg::CD_ALWAYS:      cond_true = 1'b1;
      clwc_pkg::CD_GOTO_OK:     cond_true = stat_i.goto_ok;
      clwc_pkg::CD_CONV_BUSY:   cond_true = stat_i.conv_busy;
      clwc_pkg::CD_LEAD_ZERO:   cond_true = stat_i.lead_zero;
      clwc_pkg::CD_MORE_DIGITS: cond_true = stat_i.more_digits;
      default:                  cond_true = 1'b1;
    endcase
  end

  // Next step address.
  always_comb begin
    if (!adv_o) begin
      upc_d = upc_q;
    end else if (ctrl_o.dispatch) begin
      upc_d = in_fire_o ? clwc_pkg::dispatch(opcode_i) : ctrl_o.addr_f;
    end else begin
      upc_d = cond_true ? ctrl_o.addr_t : ctrl_o.addr_f;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= clwc_pkg::A_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  // A blocked write step must not move on.
  a_hold_on_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.emit && stat_i.out_busy) |=> (upc_q == $past(upc_q)))
    else $error("step counter moved while a write was blocked");

  // Without a request the idle step stays put.
  a_idle_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == clwc_pkg::A_IDLE && !in_valid_i) |=> (upc_q == clwc_pkg::A_IDLE))
    else $error("sequencer left idle without a request");

endmodule

FILE: src/clwc_datapath.sv
module clwc_datapath #(
  parameter int COLUMNS     = clwc_pkg::ColumnsDefault,
  parameter int VALUE_WIDTH = clwc_pkg::ValueWidthDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_fire_i,
  input  logic [7:0]        data_byte_i,
  input  logic [7:0]        row_i,
  input  logic [7:0]        column_i,
  input  logic [31:0]       value_i,
  input  clwc_pkg::cfg_t    cfg_i,
  input  clwc_pkg::ctrl_t   ctrl_i,
  input  logic              adv_i,
  output clwc_pkg::stat_t   stat_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              is_data_o,
  output logic [7:0]        bus_byte_o,
  output logic              last_o
);

  // Conversion handles four binary bits per step.
  localparam int ConvSteps = (VALUE_WIDTH + 3) / 4;
  localparam int BinW      = ConvSteps * 4;
  localparam int NumDigits = (VALUE_WIDTH * 77) / 256 + 1;
  localparam int BcdW      = NumDigits * 4;
  localparam int IterW     = $clog2(ConvSteps + 1);
  localparam int CntW      = $clog2(NumDigits + 1);

  logic [7:0]      data_q;
  logic [7:0]      goto_byte_q;
  logic            goto_ok_q;
  logic [BinW-1:0] bin_q, bin_c;
  logic [BcdW-1:0] bcd_q, bcd_c;
  logic [IterW-1:0] iter_q;
  logic [CntW-1:0]  cnt_q;
  logic [3:0]      top_digit;
  logic            final_digit;
  logic            lead_zero;
  logic            out_valid_q;
  logic            is_data_q, last_q;
  logic [7:0]      bus_byte_q;
  logic [7:0]      byte_sel;
  logic            last_sel;
  logic            emit_fire;
  logic            goto_ok_d;
  logic [7:0]      goto_byte_d;

  assign top_digit   = bcd_q[BcdW-1 -: 4];
  assign final_digit = (cnt_q == CntW'(1));
  assign lead_zero   = (top_digit == 4'd0) && !final_digit;
  assign emit_fire   = adv_i && ctrl_i.emit;

  // Goto check and byte are formed at accept time.
  assign goto_ok_d   = (row_i == 8'd0 || row_i == 8'd1) && (column_i < 8'(COLUMNS));
  assign goto_byte_d = (column_i & clwc_pkg::ColMask) |
                       ((row_i == 8'd0) ? cfg_i.row0_base : cfg_i.row1_base);

  // Flags for the sequencer's jumps.
  always_comb begin
    stat_o.goto_ok     = goto_ok_q;
    stat_o.conv_busy   = (iter_q != IterW'(1));
    stat_o.lead_zero   = lead_zero;
    stat_o.more_digits = !final_digit;
    stat_o.out_busy    = out_valid_q && out_stall_i;
  end

  // One double-dabble step: four shift-and-adjust rounds.
  always_comb begin
    bcd_c = bcd_q;
    bin_c = bin_q;
    for (int s = 0; s < 4; s++) begin
      for (int k = 0; k < NumDigits; k++) begin
        if (bcd_c[k*4 +: 4] >= 4'd5) begin
          bcd_c[k*4 +: 4] = bcd_c[k*4 +: 4] + 4'd3;
        end
      end
      bcd_c = {bcd_c[BcdW-2:0], bin_c[BinW-1]};
      bin_c = {bin_c[BinW-2:0], 1'b0};
    end
  end

  // Byte source select.
  always_comb begin
    unique case (ctrl_i.src)
      clwc_pkg::SRC_FUNC:  byte_sel = cfg_i.function_set_cmd;
      clwc_pkg::SRC_DISP:  byte_sel = cfg_i.display_control_cmd;
      clwc_pkg::SRC_ICLR:  byte_sel = cfg_i.init_clear_cmd;
      clwc_pkg::SRC_ENTRY: byte_sel = cfg_i.entry_mode_cmd;
      clwc_pkg::SRC_DATA:  byte_sel = data_q;
      clwc_pkg::SRC_GOTO:  byte_sel = goto_byte_q;
      clwc_pkg::SRC_CLEAR: byte_sel = clwc_pkg::ClearCmd;
      clwc_pkg::SRC_DIGIT: byte_sel = clwc_pkg::AsciiZero | {4'd0, top_digit};
      default:             byte_sel = data_q;
    endcase
  end

  // Last-word flag select.
  always_comb begin
    unique case (ctrl_i.last)
      clwc_pkg::LAST_NO:    last_sel = 1'b0;
      clwc_pkg::LAST_YES:   last_sel = 1'b1;
      clwc_pkg::LAST_FINAL: last_sel = final_digit;
      default:              last_sel = 1'b0;
    endcase
  end

  // Step counters and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire_i) begin
        iter_q <= IterW'(ConvSteps);
        cnt_q  <= CntW'(NumDigits);
      end else if (adv_i) begin
        case (ctrl_i.op)
          clwc_pkg::DP_CONV:  iter_q <= iter_q - IterW'(1);
          clwc_pkg::DP_SKIP:  if (lead_zero) cnt_q <= cnt_q - CntW'(1);
          clwc_pkg::DP_DIGIT: cnt_q <= cnt_q - CntW'(1);
          default: ;
        endcase
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire_i) begin
      data_q      <= data_byte_i;
      goto_ok_q   <= goto_ok_d;
      goto_byte_q <= goto_byte_d;
      bin_q       <= BinW'(value_i[VALUE_WIDTH-1:0]);
      bcd_q       <= '0;
    end else if (adv_i) begin
      case (ctrl_i.op)
        clwc_pkg::DP_CONV: begin
          bin_q <= bin_c;
          bcd_q <= bcd_c;
        end
        clwc_pkg::DP_SKIP: if (lead_zero) bcd_q <= {bcd_q[BcdW-5:0], 4'd0};
        clwc_pkg::DP_DIGIT: bcd_q <= {bcd_q[BcdW-5:0], 4'd0};
        default: ;
      endcase
    end
    if (emit_fire) begin
      is_data_q  <= ctrl_i.is_data;
      bus_byte_q <= byte_sel;
      last_q     <= last_sel;
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_data_o   = is_data_q;
  assign bus_byte_o  = bus_byte_q;
  assign last_o      = last_q;

  // A write never lands on a word that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |-> !(out_valid_q && out_stall_i))
    else $error("output word overwritten while stalled");

  // Digit writes only happen while digits remain.
  a_digit_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == clwc_pkg::DP_DIGIT) |-> (cnt_q != '0))
    else $error("digit write with no digits left");

endmodule

FILE: src/char_lcd_write_controller_core.sv
// Each request runs a microprogram from the idle step; bus words leave through a
// one-word output register. A goto first checks its row and column, then writes; a
// number runs the decimal conversion loop (four bits per step), skips leading zeros,
// then writes its digits. A new request is taken only once the sequencer is back at
// idle, and a write step waits while the output register is full and stalled.
// Reset: asynchronous, active low; sequencer idles, output empties, registers take defaults.
module char_lcd_write_controller_core #(
  parameter int COLUMNS     = clwc_pkg::ColumnsDefault,
  parameter int VALUE_WIDTH = clwc_pkg::ValueWidthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [clwc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [2:0]                   opcode_i,
  input  logic [7:0]                   data_byte_i,
  input  logic [7:0]                   row_i,
  input  logic [7:0]                   column_i,
  input  logic [31:0]                  value_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         is_data_o,
  output logic [7:0]                   bus_byte_o,
  output logic                         last_o
);

  clwc_pkg::cfg_t  cfg;
  clwc_pkg::ctrl_t ctrl;
  clwc_pkg::stat_t stat;
  logic            adv;
  logic            in_fire;

  // Configuration registers.
  clwc_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Microprogram sequencer.
  clwc_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .opcode_i   (opcode_i),
    .in_stall_o (in_stall_o),
    .in_fire_o  (in_fire),
    .stat_i     (stat),
    .ctrl_o     (ctrl),
    .adv_o      (adv)
  );

  // Datapath with decimal converter and output register.
  clwc_datapath #(
    .COLUMNS     (COLUMNS),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .data_byte_i (data_byte_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .value_i     (value_i),
    .cfg_i       (cfg),
    .ctrl_i      (ctrl),
    .adv_i       (adv),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_data_o   (is_data_o),
    .bus_byte_o  (bus_byte_o),
    .last_o      (last_o)
  );

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int unsigned Columns      = clwc_pkg::ColumnsDefault;
  localparam int unsigned Radix        = 10;
  localparam logic [2:0]  OpSpare6     = 3'd6;
  localparam logic [2:0]  OpSpare7     = 3'd7;
  localparam int unsigned DirectedLen  = 24;
  localparam int unsigned PhaseItems   = 43;
  localparam int unsigned RxHoldCycles = 300;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned MaxPrinted   = 100;
  localparam longint      TimeoutNs    = 64'd10_000_000;

  // One bus write as the display sees it.
  typedef struct packed {
    logic       is_data;
    logic [7:0] bus_byte;
    logic       last;
  } bus_word_t;

  // Request fields for the directed list.
  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  data_byte;
    logic [7:0]  row;
    logic [7:0]  column;
    logic [31:0] value;
  } lcd_request_t;

  // Predicts the bus writes of each request and checks the words that come out.
  class lcd_write_scoreboard;
    clwc_pkg::cfg_t regs;
    bus_word_t      burst_q[$];
    bus_word_t      bus_word_q[$];
    int unsigned    errors;

    function new();
      regs.function_set_cmd    = clwc_pkg::FunctionSetRst;
      regs.display_control_cmd = clwc_pkg::DisplayCtrlRst;
      regs.init_clear_cmd      = clwc_pkg::InitClearRst;
      regs.entry_mode_cmd      = clwc_pkg::EntryModeRst;
      regs.row0_base           = clwc_pkg::Row0BaseRst;
      regs.row1_base           = clwc_pkg::Row1BaseRst;
      errors                   = 0;
    endfunction

    // Unknown indexes leave the registers as they are.
    function void write_reg(logic [2:0] index, logic [7:0] data);
      case (index)
        clwc_pkg::REG_FUNCTION_SET: regs.function_set_cmd    = data;
        clwc_pkg::REG_DISPLAY_CTRL: regs.display_control_cmd = data;
        clwc_pkg::REG_INIT_CLEAR:   regs.init_clear_cmd      = data;
        clwc_pkg::REG_ENTRY_MODE:   regs.entry_mode_cmd      = data;
        clwc_pkg::REG_ROW0_BASE:    regs.row0_base           = data;
        clwc_pkg::REG_ROW1_BASE:    regs.row1_base           = data;
        default: ;
      endcase
    endfunction

    function void add_word(logic is_data, logic [7:0] bus_byte);
      burst_q.push_back('{is_data, bus_byte, 1'b0});
    endfunction

    // Expands one accepted request into its expected bus writes.
    function void note_request(logic [2:0] opcode, logic [7:0] data_byte, logic [7:0] row,
                               logic [7:0] column, logic [31:0] value);
      logic [31:0] rest;
      logic [7:0]  digit_q[$];
      logic [7:0]  base;
      burst_q.delete();
      case (opcode)
        clwc_pkg::OP_INIT: begin
          add_word(1'b0, regs.function_set_cmd);
          add_word(1'b0, regs.display_control_cmd);
          add_word(1'b0, regs.init_clear_cmd);
          add_word(1'b0, regs.entry_mode_cmd);
        end
        clwc_pkg::OP_CMD:   add_word(1'b0, data_byte);
        clwc_pkg::OP_CHAR:  add_word(1'b1, data_byte);
        clwc_pkg::OP_CLEAR: add_word(1'b0, clwc_pkg::ClearCmd);
        clwc_pkg::OP_GOTO: begin
          // Rows other than 0 and 1, or columns past the display, write nothing.
          if (column < Columns && row <= 8'd1) begin
            base = (row == 8'd0) ? regs.row0_base : regs.row1_base;
            add_word(1'b0, (column & clwc_pkg::ColMask) | base);
          end
        end
        clwc_pkg::OP_NUMBER: begin
          // Decimal digits, most significant first, a lone zero for zero.
          rest = value;
          do begin
            digit_q.push_front(clwc_pkg::AsciiZero + 8'(rest % Radix));
            rest = rest / Radix;
          end while (rest != 0);
          foreach (digit_q[k]) add_word(1'b1, digit_q[k]);
        end
        default: ;
      endcase
      if (burst_q.size() > 0) burst_q[burst_q.size() - 1].last = 1'b1;
      foreach (burst_q[k]) bus_word_q.push_back(burst_q[k]);
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (errors <= MaxPrinted) $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    // Compares one accepted output word against the oldest expectation.
    task check_word(logic is_data, logic [7:0] bus_byte, logic last);
      bus_word_t exp_word;
      if (bus_word_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word is_data=%0b byte=%02h last=%0b",
                                  is_data, bus_byte, last));
        return;
      end
      exp_word = bus_word_q.pop_front();
      if (is_data !== exp_word.is_data)
        report_mismatch($sformatf("is_data %0b, expected %0b", is_data, exp_word.is_data));
      if (bus_byte !== exp_word.bus_byte)
        report_mismatch($sformatf("bus_byte %02h, expected %02h", bus_byte,
                                  exp_word.bus_byte));
      if (last !== exp_word.last)
        report_mismatch($sformatf("last %0b, expected %0b", last, exp_word.last));
    endtask
  endclass

  logic         clk_i       = 1'b0;
  logic         rst_ni      = 1'b0;
  logic         cfg_valid_i = 1'b0;
  logic         cfg_ready_o;
  logic [2:0]   cfg_index_i = '0;
  logic [7:0]   cfg_data_i  = '0;
  logic         in_valid_i  = 1'b0;
  logic         in_stall_o;
  logic [2:0]   opcode_i    = '0;
  logic [7:0]   data_byte_i = '0;
  logic [7:0]   row_i       = '0;
  logic [7:0]   column_i    = '0;
  logic [31:0]  value_i     = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic         is_data_o;
  logic [7:0]   bus_byte_o;
  logic         last_o;

  logic         no_gaps     = 1'b0;
  logic         rx_hold_req = 1'b0;

  lcd_write_scoreboard sb = new();

  char_lcd_write_controller_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .data_byte_i (data_byte_i),
    .row_i       (row_i),
    .column_i    (column_i),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .is_data_o   (is_data_o),
    .bus_byte_o  (bus_byte_o),
    .last_o      (last_o)
  );

  always #10 clk_i = ~clk_i;

  // Monitors see the values from just before each rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
    if (rst_ni && in_valid_i && !in_stall_o)
      sb.note_request(opcode_i, data_byte_i, row_i, column_i, value_i);
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_word(is_data_o, bus_byte_o, last_o);
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned gap_cycles();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 30);
    return $urandom_range(1, 3);
  endfunction

  // Receiver side: random stalls, or one long hold-off when asked.
  initial begin
    forever begin
      if (rx_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (RxHoldCycles) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end else if (no_gaps || $urandom_range(0, 2) != 0) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat (gap_cycles()) @(posedge clk_i);
      end
    end
  end

  // Offers one request and returns at the edge that takes it; valid stays high.
  task automatic send_request(lcd_request_t req);
    int unsigned gap;
    gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : gap_cycles();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= req.opcode;
    data_byte_i <= req.data_byte;
    row_i       <= req.row;
    column_i    <= req.column;
    value_i     <= req.value;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Random request with a bias toward numbers and in-range gotos.
  task automatic send_random_request();
    lcd_request_t req;
    int unsigned  pick;
    req.data_byte = 8'($urandom_range(0, 255));
    req.row       = 8'($urandom_range(0, 255));
    req.column    = 8'($urandom_range(0, 255));
    req.value     = $urandom();
    pick          = $urandom_range(0, 19);
    if (pick < 5) begin
      req.opcode = clwc_pkg::OP_NUMBER;
      req.value  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 9)
                                               : $urandom() >> $urandom_range(0, 31);
    end else if (pick < 9) begin
      req.opcode = clwc_pkg::OP_GOTO;
      if ($urandom_range(0, 7) != 0) req.row = 8'($urandom_range(0, 1));
      if ($urandom_range(0, 7) != 0) req.column = 8'($urandom_range(0, Columns - 1));
    end else if (pick < 12) begin
      req.opcode = clwc_pkg::OP_CHAR;
    end else if (pick < 14) begin
      req.opcode = clwc_pkg::OP_CMD;
    end else if (pick < 16) begin
      req.opcode = clwc_pkg::OP_INIT;
    end else if (pick < 18) begin
      req.opcode = clwc_pkg::OP_CLEAR;
    end else begin
      req.opcode = $urandom_range(0, 1) ? OpSpare6 : OpSpare7;
    end
    send_request(req);
  endtask

  // Drops valid, waits out every expected word, then lets the block settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (sb.bus_word_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all six registers and both unused indexes while the block is idle.
  task automatic program_regs(clwc_pkg::cfg_t c);
    logic [7:0] vals[8];
    vals = '{c.function_set_cmd, c.display_control_cmd, c.init_clear_cmd,
             c.entry_mode_cmd, c.row0_base, c.row1_base,
             8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
    for (int i = 0; i < 8; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= 3'(i);
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Run limit.
  initial begin
    #(TimeoutNs);
    $display("tb: failure");
    $finish;
  end

  // Main sequence: directed requests on reset values, then random phases
  // under several register settings.
  initial begin
    lcd_request_t   directed[DirectedLen];
    clwc_pkg::cfg_t setting;
    directed = '{
      '{clwc_pkg::OP_INIT,   8'h5a, 8'h00, 8'h00, 32'd0},
      '{clwc_pkg::OP_CMD,    8'h00, 8'hff, 8'hff, 32'hffff_ffff},
      '{clwc_pkg::OP_CMD,    8'hff, 8'h00, 8'h00, 32'd0},
      '{clwc_pkg::OP_CHAR,   8'h00, 8'h01, 8'h0f, 32'd5},
      '{clwc_pkg::OP_CHAR,   8'hff, 8'h02, 8'h10, 32'd6},
      '{clwc_pkg::OP_CHAR,   8'ha5, 8'h00, 8'h00, 32'd7},
      '{clwc_pkg::OP_GOTO,   8'h00, 8'h00, 8'h00, 32'd0},
      '{clwc_pkg::OP_GOTO,   8'hff, 8'h00, 8'h0f, 32'd0},
      '{clwc_pkg::OP_GOTO,   8'h00, 8'h01, 8'h00, 32'd0},
      '{clwc_pkg::OP_GOTO,   8'h00, 8'h01, 8'h0f, 32'd0},
      '{clwc_pkg::OP_GOTO,   8'h00, 8'h00, 8'h10, 32'd0},
      '{clwc_pkg::OP_GOTO,   8'h00, 8'h02, 8'h00, 32'd0},
      '{clwc_pkg::OP_GOTO,   8'h00, 8'hff, 8'hff, 32'd0},
      '{clwc_pkg::OP_GOTO,   8'h00, 8'h01, 8'hff, 32'd0},
      '{clwc_pkg::OP_CLEAR,  8'h77, 8'h00, 8'h00, 32'd0},
      '{clwc_pkg::OP_NUMBER, 8'h00, 8'h00, 8'h00, 32'd0},
      '{clwc_pkg::OP_NUMBER, 8'h00, 8'h00, 8'h00, 32'd9},
      '{clwc_pkg::OP_NUMBER, 8'h00, 8'h00, 8'h00, 32'd10},
      '{clwc_pkg::OP_NUMBER, 8'h00, 8'h00, 8'h00, 32'hffff_ffff},
      '{clwc_pkg::OP_NUMBER, 8'h00, 8'h00, 8'h00, 32'd1_000_000_000},
      '{clwc_pkg::OP_NUMBER, 8'h00, 8'h00, 8'h00, 32'd999_999_999},
      '{OpSpare6,            8'hff, 8'h01, 8'h05, 32'd123},
      '{OpSpare7,            8'h00, 8'h00, 8'h00, 32'hffff_ffff},
      '{clwc_pkg::OP_INIT,   8'h00, 8'hff, 8'hff, 32'hffff_ffff}
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[k]) send_request(directed[k]);
    for (int phase = 0; phase < 6; phase++) begin
      if (phase > 0) begin
        // Registers change only once the block has drained.
        wait_idle();
        case (phase)
          1:       setting = '0;
          2:       setting = '1;
          default: setting = clwc_pkg::cfg_t'({$urandom(), 16'($urandom())});
        endcase
        program_regs(setting);
      end
      // All-zero registers run with no idling at all; the all-ones phase
      // holds the output off long enough to back the input up.
      no_gaps = (phase == 1);
      if (phase == 2) rx_hold_req = 1'b1;
      repeat (PhaseItems) send_random_request();
    end

    wait_idle();
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
src/clwc_pkg.sv
src/clwc_cfg_regs.sv
src/clwc_sequencer.sv
src/clwc_datapath.sv
src/char_lcd_write_controller_core.sv
bench/tb_top.sv
